FILE: hdl/tiq_pkg.sv
// ----------------------------------------------------------------------------
// tiq_pkg
// Shared types and codes for the trackball input qualifier.
// ----------------------------------------------------------------------------
package tiq_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  // register indexes
  localparam logic [CfgAddrW-1:0] CFG_COUNT_THRESHOLD   = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_LONG_PRESS_MS     = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_LONG_REPEAT_MS    = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_DEBOUNCE_MS       = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_IDLE_CLEAR_MS     = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_HOLD_REPEAT_POLLS = 3'd5;

  // register reset values
  localparam logic [7:0]  RST_COUNT_THRESHOLD   = 8'd0;
  localparam logic [15:0] RST_LONG_PRESS_MS     = 16'd500;
  localparam logic [15:0] RST_LONG_REPEAT_MS    = 16'd500;
  localparam logic [7:0]  RST_DEBOUNCE_MS       = 8'd10;
  localparam logic [15:0] RST_IDLE_CLEAR_MS     = 16'd1000;
  localparam logic [7:0]  RST_HOLD_REPEAT_POLLS = 8'd3;

  // item commands
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // lines
  localparam logic [2:0] LINE_PRESS = 3'd0;
  localparam logic [2:0] LINE_LAST  = 3'd4;

  // pending actions and event codes
  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_UP           = 3'd1;
  localparam logic [2:0] ACT_DOWN         = 3'd2;
  localparam logic [2:0] ACT_LEFT         = 3'd3;
  localparam logic [2:0] ACT_RIGHT        = 3'd4;
  localparam logic [2:0] ACT_PRESSED      = 3'd5;
  localparam logic [2:0] ACT_PRESSED_LONG = 3'd6;
  localparam logic [2:0] EV_SHORT         = 3'd5;
  localparam logic [2:0] EV_LONG          = 3'd6;

  localparam logic [7:0] CNT_MAX = 8'hFF;
  localparam int         NUM_DIRS = 4;

  typedef struct packed {
    logic [7:0]  count_threshold;
    logic [15:0] long_press_ms;
    logic [15:0] long_repeat_ms;
    logic [7:0]  debounce_ms;
    logic [15:0] idle_clear_ms;
    logic [7:0]  hold_repeat_polls;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  edge_line;
    logic [31:0] now_ms;
    logic [4:0]  pin_levels;
  } item_t;

endpackage

FILE: hdl/trackball_input_qualifier.sv
// ----------------------------------------------------------------------------
// trackball_input_qualifier
// Debounce, long press with auto-repeat and direction hold-repeat for a
// five-line trackball; edge and poll words in, event codes out.
// ----------------------------------------------------------------------------
// The block takes one edge or poll word per clock cycle while the result
// register is free or being drained. A word is captured in the input
// register, processed combinationally against the qualifier state, and a poll
// that yields an event loads it into the result register, which drives
// out_valid. While a result waits unread, the input register takes one more
// word and then holds it until the result is drained. Configuration writes
// take effect at once and are expected only while no word is in flight.
module trackball_input_qualifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [2:0]                    in_edge_line,
  input  logic [31:0]                   in_now_ms,
  input  logic [4:0]                    in_pin_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_event_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tiq_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [tiq_pkg::CfgDataW-1:0]  cfg_data
);
  import tiq_pkg::*;

  cfg_t       cfg;
  item_t      s1_item_r;
  logic       s1_valid_r;
  logic       out_valid_r;
  logic [2:0] out_code_r;
  logic [2:0] ev_code;
  logic       advance;

  assign cfg_ready = 1'b1;

  tiq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // advance the captured word when the result slot is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.cmd        <= in_cmd;
      s1_item_r.edge_line  <= in_edge_line;
      s1_item_r.now_ms     <= in_now_ms;
      s1_item_r.pin_levels <= in_pin_levels;
    end
  end

  tiq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (advance),
    .item    (s1_item_r),
    .ev_code (ev_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= ev_code != ACT_NONE;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev_code != ACT_NONE) out_code_r <= ev_code;
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

endmodule

FILE: hdl/tiq_cfg_regs.sv
// ----------------------------------------------------------------------------
// tiq_cfg_regs
// Configuration register bank, written one word per handshake.
// ----------------------------------------------------------------------------
module tiq_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [tiq_pkg::CfgAddrW-1:0]  wr_addr,
  input  logic [tiq_pkg::CfgDataW-1:0]  wr_data,
  output tiq_pkg::cfg_t                 cfg
);
  import tiq_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_threshold   <= RST_COUNT_THRESHOLD;
      cfg_r.long_press_ms     <= RST_LONG_PRESS_MS;
      cfg_r.long_repeat_ms    <= RST_LONG_REPEAT_MS;
      cfg_r.debounce_ms       <= RST_DEBOUNCE_MS;
      cfg_r.idle_clear_ms     <= RST_IDLE_CLEAR_MS;
      cfg_r.hold_repeat_polls <= RST_HOLD_REPEAT_POLLS;
    end else if (wr_en) begin
      unique case (wr_addr)
        CFG_COUNT_THRESHOLD:   cfg_r.count_threshold   <= wr_data[7:0];
        CFG_LONG_PRESS_MS:     cfg_r.long_press_ms     <= wr_data;
        CFG_LONG_REPEAT_MS:    cfg_r.long_repeat_ms    <= wr_data;
        CFG_DEBOUNCE_MS:       cfg_r.debounce_ms       <= wr_data[7:0];
        CFG_IDLE_CLEAR_MS:     cfg_r.idle_clear_ms     <= wr_data;
        CFG_HOLD_REPEAT_POLLS: cfg_r.hold_repeat_polls <= wr_data[7:0];
        default: ;  // unmapped index: drop
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/tiq_core.sv
// ----------------------------------------------------------------------------
// tiq_core
// Qualifier state and its update for one edge or poll word.
// ----------------------------------------------------------------------------
module tiq_core (
  input  logic           clk,
  input  logic           rst_n,
  input  tiq_pkg::cfg_t  cfg,
  input  logic           step,
  input  tiq_pkg::item_t item,
  output logic [2:0]     ev_code
);
  import tiq_pkg::*;

  logic [2:0]  pend_r, pend_nxt;
  logic [31:0] last_edge_r, last_edge_nxt;
  logic        seen_r, seen_nxt;
  logic [7:0]  dcnt_r [NUM_DIRS];
  logic [7:0]  dcnt_nxt [NUM_DIRS];
  logic        press_r, press_nxt;
  logic [31:0] press_start_r, press_start_nxt;
  logic [31:0] last_long_r, last_long_nxt;
  logic        long_sent_r, long_sent_nxt;
  logic        hold_r, hold_nxt;
  logic [31:0] hold_start_r, hold_start_nxt;
  logic [7:0]  hold_cnt_r, hold_cnt_nxt;
  logic [2:0]  ev;

  logic        thr_on;
  logic [31:0] edge_diff, press_dur, hold_dur, long_diff;
  logic        bounce_hit;
  logic [7:0]  hold_inc;
  logic [2:0]  held_dir;
  logic [1:0]  edge_idx;

  assign thr_on     = cfg.count_threshold != 8'd0;
  assign edge_diff  = item.now_ms - last_edge_r;
  assign press_dur  = item.now_ms - press_start_r;
  assign hold_dur   = item.now_ms - hold_start_r;
  assign long_diff  = item.now_ms - last_long_r;
  assign bounce_hit = seen_r && (edge_diff < {24'd0, cfg.debounce_ms});
  assign hold_inc   = (hold_cnt_r != CNT_MAX) ? hold_cnt_r + 8'd1 : hold_cnt_r;
  assign edge_idx   = 2'(item.edge_line - 3'd1);

  // up wins over down, down over left, left over right
  always_comb begin
    priority if (!item.pin_levels[1]) held_dir = ACT_UP;
    else if (!item.pin_levels[2])     held_dir = ACT_DOWN;
    else if (!item.pin_levels[3])     held_dir = ACT_LEFT;
    else if (!item.pin_levels[4])     held_dir = ACT_RIGHT;
    else                              held_dir = ACT_NONE;
  end

  always_comb begin
    pend_nxt        = pend_r;
    last_edge_nxt   = last_edge_r;
    seen_nxt        = seen_r;
    dcnt_nxt        = dcnt_r;
    press_nxt       = press_r;
    press_start_nxt = press_start_r;
    last_long_nxt   = last_long_r;
    long_sent_nxt   = long_sent_r;
    hold_nxt        = hold_r;
    hold_start_nxt  = hold_start_r;
    hold_cnt_nxt    = hold_cnt_r;
    ev              = ACT_NONE;

    if (item.cmd == CMD_EDGE) begin
      if (item.edge_line <= LINE_LAST) begin
        if (item.edge_line == LINE_PRESS) begin
          if (!bounce_hit) pend_nxt = ACT_PRESSED;
        end else begin
          if (thr_on || !bounce_hit) pend_nxt = item.edge_line;
          if (thr_on && dcnt_r[edge_idx] != CNT_MAX)
            dcnt_nxt[edge_idx] = dcnt_r[edge_idx] + 8'd1;
        end
        last_edge_nxt = item.now_ms;
        seen_nxt      = 1'b1;
      end
    end else begin
      // idle clear of the direction counters
      if (thr_on && seen_r && edge_diff >= {16'd0, cfg.idle_clear_ms}) begin
        for (int i = 0; i < NUM_DIRS; i++) dcnt_nxt[i] = 8'd0;
        seen_nxt = 1'b0;
      end

      if (press_r) begin
        if (item.pin_levels[0]) begin
          if (press_dur < {16'd0, cfg.long_press_ms}) ev = EV_SHORT;
          press_nxt       = 1'b0;
          press_start_nxt = 32'd0;
          last_long_nxt   = 32'd0;
          long_sent_nxt   = 1'b0;
          pend_nxt        = ACT_NONE;
        end else if (press_dur >= {16'd0, cfg.long_press_ms}) begin
          if (!long_sent_r || long_diff >= {16'd0, cfg.long_repeat_ms}) begin
            ev            = EV_LONG;
            last_long_nxt = item.now_ms;
            long_sent_nxt = 1'b1;
          end
          pend_nxt = ACT_PRESSED_LONG;
        end
      end

      if (hold_r) begin
        hold_cnt_nxt = hold_inc;
        if (held_dir == ACT_NONE) begin
          hold_nxt       = 1'b0;
          hold_start_nxt = 32'd0;
          hold_cnt_nxt   = 8'd0;
          pend_nxt       = ACT_NONE;
        end else if (hold_dur >= {16'd0, cfg.long_press_ms} &&
                     hold_inc >= cfg.hold_repeat_polls) begin
          ev           = held_dir;
          hold_cnt_nxt = 8'd0;
        end
      end

      if (thr_on) begin
        if (pend_nxt == ACT_PRESSED && !press_nxt) begin
          press_nxt       = 1'b1;
          press_start_nxt = item.now_ms;
        end else begin
          // walk down so the lowest direction wins
          for (int i = NUM_DIRS - 1; i >= 0; i--)
            if (dcnt_nxt[i] >= cfg.count_threshold) ev = 3'(i + 1);
        end
      end else begin
        if (pend_nxt == ACT_PRESSED && !item.pin_levels[0] && !press_nxt) begin
          press_nxt       = 1'b1;
          press_start_nxt = item.now_ms;
        end else if (pend_nxt >= ACT_UP && pend_nxt <= ACT_RIGHT &&
                     !item.pin_levels[pend_nxt] && !hold_nxt) begin
          hold_nxt       = 1'b1;
          hold_start_nxt = item.now_ms;
          ev             = pend_nxt;
        end
      end

      if (ev != ACT_NONE && thr_on)
        for (int i = 0; i < NUM_DIRS; i++) dcnt_nxt[i] = 8'd0;

      if (!press_nxt) pend_nxt = ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r        <= ACT_NONE;
      last_edge_r   <= 32'd0;
      seen_r        <= 1'b0;
      for (int i = 0; i < NUM_DIRS; i++) dcnt_r[i] <= 8'd0;
      press_r       <= 1'b0;
      press_start_r <= 32'd0;
      last_long_r   <= 32'd0;
      long_sent_r   <= 1'b0;
      hold_r        <= 1'b0;
      hold_start_r  <= 32'd0;
      hold_cnt_r    <= 8'd0;
    end else if (step) begin
      pend_r        <= pend_nxt;
      last_edge_r   <= last_edge_nxt;
      seen_r        <= seen_nxt;
      dcnt_r        <= dcnt_nxt;
      press_r       <= press_nxt;
      press_start_r <= press_start_nxt;
      last_long_r   <= last_long_nxt;
      long_sent_r   <= long_sent_nxt;
      hold_r        <= hold_nxt;
      hold_start_r  <= hold_start_nxt;
      hold_cnt_r    <= hold_cnt_nxt;
    end
  end

  assign ev_code = ev;

`ifndef SYNTHESIS
  a_hold_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_r |-> hold_cnt_r == 8'd0)
    else $error("hold poll count nonzero without an active hold");

  a_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    !press_r |-> !long_sent_r)
    else $error("long press marked sent without an active press");

  a_long_pend_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    !press_r |-> pend_r != ACT_PRESSED_LONG)
    else $error("long press pending without an active press");

  a_edge_silent: assert property (@(posedge clk) disable iff (!rst_n)
    item.cmd == CMD_EDGE |-> ev_code == ACT_NONE)
    else $error("edge word produced an event");
`endif

endmodule
